// ----- sv/lcp_pkg.sv -----
// shared types, codes and constants of the line command parser
package lcp_pkg;

    localparam int LINE_BYTES_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_RR_ENABLE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VBAT_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_ENABLE = 2'd2;

    localparam logic [2:0] ST_REJECT    = 3'd0;
    localparam logic [2:0] ST_RR        = 3'd1;
    localparam logic [2:0] ST_VBAT      = 3'd2;
    localparam logic [2:0] ST_SCAN_ON   = 3'd3;
    localparam logic [2:0] ST_SCAN_OFF  = 3'd4;
    localparam logic [2:0] ST_NO_ACTION = 3'd5;

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_END  = 2'd1;
    localparam logic [1:0] CMD_DROP = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // keywords left-aligned, first character in the top byte
    localparam logic [31:0] KW_RR   = 32'h5252_0000;
    localparam logic [31:0] KW_VBAT = 32'h5642_4154;
    localparam logic [31:0] KW_SCAN = 32'h5343_414E;
    localparam logic [31:0] KW_ON   = 32'h6F6E_0000;
    localparam logic [31:0] KW_OFF  = 32'h6F66_6600;

    localparam logic [2:0] LEN_RR   = 3'd2;
    localparam logic [2:0] LEN_VBAT = 3'd4;
    localparam logic [2:0] LEN_SCAN = 3'd4;
    localparam logic [2:0] LEN_ON   = 3'd2;
    localparam logic [2:0] LEN_OFF  = 3'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_lcp_cmd;

    typedef struct packed {
        logic [2:0]  line_status;
        logic [15:0] first_value;
        logic [15:0] second_value;
    } t_lcp_result;

    typedef struct packed {
        logic rr_enable;
        logic vbat_enable;
        logic scan_enable;
    } t_lcp_cfg;

endpackage

// ----- sv/line_command_parser_top.sv -----
// top level of the line command parser: enable registers and front/queue/back hookup
// Takes one received byte per request and returns one result request per non-empty
// line: status (reject, rr, vbat, scan on, scan off, no action) and up to two 16-bit
// values. Bytes are parsed on the fly as they leave a two-entry command queue, so no
// line buffer is kept; a line result is registered at the edge that takes its
// newline out of the queue. Sustained rate is one byte per clock while results are
// taken; a line that reaches LINE_BYTES bytes is dropped without a result. The rr,
// vbat and scan enables reset to 1 and are sampled when the newline is processed.
module line_command_parser_top #(
    parameter int LINE_BYTES = lcp_pkg::LINE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lcp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2:0]                    o_line_status,
    output logic [15:0]                   o_first_value,
    output logic [15:0]                   o_second_value
);
    import lcp_pkg::*;

    t_lcp_cfg    r_cfg;
    t_lcp_cmd    front_cmd;
    logic        front_valid;
    logic        queue_ready;
    logic        queue_valid;
    t_lcp_cmd    queue_cmd;
    logic        back_pop;
    t_lcp_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{rr_enable: 1'b1, vbat_enable: 1'b1, scan_enable: 1'b1};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RR_ENABLE:   r_cfg.rr_enable   <= i_cfg_data;
                CFG_VBAT_ENABLE: r_cfg.vbat_enable <= i_cfg_data;
                CFG_SCAN_ENABLE: r_cfg.scan_enable <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    lcp_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (queue_ready)
    );

    lcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd),
        .i_pop   (back_pop)
    );

    lcp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (back_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_line_status  = result.line_status;
    assign o_first_value  = result.first_value;
    assign o_second_value = result.second_value;

endmodule

// ----- sv/lcp_front.sv -----
// front end: takes bytes, counts the line fill and classifies each request
module lcp_front #(
    parameter int LINE_BYTES = lcp_pkg::LINE_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_rx_byte,
    output logic            o_cmd_valid,
    output lcp_pkg::t_lcp_cmd o_cmd,
    input  logic            i_cmd_ready
);
    import lcp_pkg::*;

    localparam int CNT_W = $clog2(LINE_BYTES);

    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic             is_nl;
    logic             is_last;
    logic             accept;

    always_comb begin
        is_nl       = (i_rx_byte == CH_NL);
        is_last     = (r_fill == CNT_W'(LINE_BYTES - 1));
        o_in_ready  = i_cmd_ready;
        accept      = i_in_valid && i_cmd_ready;
        // empty line needs no work in the back end
        o_cmd_valid = i_in_valid && !(is_nl && (r_fill == '0));
        o_cmd.data  = i_rx_byte;
        if (is_nl) begin
            o_cmd.kind = CMD_END;
        end else if (is_last) begin
            o_cmd.kind = CMD_DROP;
        end else begin
            o_cmd.kind = CMD_BYTE;
        end
        n_fill = r_fill;
        if (accept) begin
            if (is_nl || is_last) begin
                n_fill = '0;
            end else begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

// ----- sv/lcp_queue.sv -----
// short command queue between front and back end
module lcp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lcp_pkg::t_lcp_cmd i_cmd,
    output logic              o_ready,
    output logic              o_valid,
    output lcp_pkg::t_lcp_cmd o_cmd,
    input  logic              i_pop
);
    import lcp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_lcp_cmd         r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
        o_valid = (r_count != '0);
        o_cmd   = r_slot[r_rd_ptr];
        do_push = i_push && o_ready;
        do_pop  = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- sv/lcp_back.sv -----
// back end: streaming tokenizer, keyword match, number conversion, result register
module lcp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lcp_pkg::t_lcp_cfg    i_cfg,
    input  logic                 i_cmd_valid,
    input  lcp_pkg::t_lcp_cmd    i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lcp_pkg::t_lcp_result o_result
);
    import lcp_pkg::*;

    localparam logic [1:0] NUM_LEAD  = 2'd0;
    localparam logic [1:0] NUM_SIGN  = 2'd1;
    localparam logic [1:0] NUM_DIGIT = 2'd2;
    localparam logic [1:0] NUM_STOP  = 2'd3;

    typedef struct packed {
        logic [1:0]  phase;
        logic        neg;
        logic [15:0] val;
    } t_num;

    function automatic logic char_match(input logic [31:0] word, input logic [2:0] wlen,
                                        input logic [2:0] pos, input logic [7:0] c);
        logic [7:0] w;
        w = word[{~pos[1:0], 3'b000} +: 8];
        return (pos < wlen) && (c == w);
    endfunction

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic t_num num_step(input t_num s, input logic [7:0] c);
        t_num       r;
        logic       digit;
        logic [15:0] acc;
        r     = s;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        acc   = {s.val[12:0], 3'b000} + {s.val[14:0], 1'b0} + {8'd0, c - CH_ZERO};
        case (s.phase)
            NUM_LEAD: begin
                if (c inside {[8'd9:8'd13]}) begin
                    r.phase = NUM_LEAD;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    r.neg   = (c == CH_MINUS);
                    r.phase = NUM_SIGN;
                end else if (digit) begin
                    r.val   = acc;
                    r.phase = NUM_DIGIT;
                end else begin
                    r.phase = NUM_STOP;
                end
            end
            NUM_SIGN, NUM_DIGIT: begin
                if (digit) begin
                    r.val   = acc;
                    r.phase = NUM_DIGIT;
                end else begin
                    r.phase = NUM_STOP;
                end
            end
            default: begin
                r.phase = NUM_STOP;
            end
        endcase
        return r;
    endfunction

    function automatic logic [15:0] num_value(input t_num s);
        return s.neg ? 16'(16'd0 - s.val) : s.val;
    endfunction

    localparam t_num NUM_INIT = '{phase: NUM_LEAD, neg: 1'b0, val: 16'd0};

    logic        r_ended, n_ended;
    logic        r_in_tok, n_in_tok;
    logic [2:0]  r_ntok, n_ntok;
    logic [2:0]  r_t0_len, n_t0_len;
    logic        r_t0_rr, n_t0_rr;
    logic        r_t0_vbat, n_t0_vbat;
    logic        r_t0_scan, n_t0_scan;
    logic [2:0]  r_t1_len, n_t1_len;
    logic        r_t1_on, n_t1_on;
    logic        r_t1_off, n_t1_off;
    t_num        r_num1, n_num1;
    t_num        r_num2, n_num2;
    logic        r_out_valid, n_out_valid;
    t_lcp_result r_result, n_result;

    logic [2:0]  tok_idx;
    logic [7:0]  c;
    logic [7:0]  c_low;
    logic        kw_rr, kw_vbat, kw_scan;
    t_lcp_result line_res;

    always_comb begin
        c      = i_cmd.data;
        c_low  = fold_lower(c);
        kw_rr   = r_t0_rr && (r_t0_len == LEN_RR);
        kw_vbat = r_t0_vbat && (r_t0_len == LEN_VBAT);
        kw_scan = r_t0_scan && (r_t0_len == LEN_SCAN);

        line_res = '{line_status: ST_NO_ACTION, first_value: 16'd0, second_value: 16'd0};
        if (r_ntok == 3'd0) begin
            line_res.line_status = ST_REJECT;
        end else if (i_cfg.rr_enable && kw_rr) begin
            if (r_ntok >= 3'd3) begin
                line_res.line_status  = ST_RR;
                line_res.first_value  = num_value(r_num1);
                line_res.second_value = num_value(r_num2);
            end else begin
                line_res.line_status = ST_REJECT;
            end
        end else if (i_cfg.vbat_enable && kw_vbat) begin
            if (r_ntok >= 3'd2) begin
                line_res.line_status = ST_VBAT;
                line_res.first_value = num_value(r_num1);
            end else begin
                line_res.line_status = ST_REJECT;
            end
        end else if (i_cfg.scan_enable && kw_scan) begin
            if (r_ntok < 3'd2) begin
                line_res.line_status = ST_REJECT;
            end else if (r_t1_on && (r_t1_len == LEN_ON)) begin
                line_res.line_status = ST_SCAN_ON;
            end else if (r_t1_off && (r_t1_len == LEN_OFF)) begin
                line_res.line_status = ST_SCAN_OFF;
            end
        end

        o_cmd_pop = i_cmd_valid &&
                    ((i_cmd.kind != CMD_END) || !r_out_valid || i_out_ready);

        n_ended   = r_ended;
        n_in_tok  = r_in_tok;
        n_ntok    = r_ntok;
        n_t0_len  = r_t0_len;
        n_t0_rr   = r_t0_rr;
        n_t0_vbat = r_t0_vbat;
        n_t0_scan = r_t0_scan;
        n_t1_len  = r_t1_len;
        n_t1_on   = r_t1_on;
        n_t1_off  = r_t1_off;
        n_num1    = r_num1;
        n_num2    = r_num2;
        n_result  = r_result;
        n_out_valid = r_out_valid && !i_out_ready;
        tok_idx   = r_in_tok ? r_ntok - 3'd1 : r_ntok;

        if (o_cmd_pop) begin
            if (i_cmd.kind == CMD_BYTE) begin
                if (!r_ended) begin
                    if (c == CH_NUL) begin
                        n_ended = 1'b1;
                    end else if (c == CH_SPACE) begin
                        n_in_tok = 1'b0;
                    end else begin
                        if (!r_in_tok) begin
                            n_in_tok = 1'b1;
                            if (r_ntok != 3'd4) begin
                                n_ntok = r_ntok + 3'd1;
                            end
                        end
                        case (tok_idx)
                            3'd0: begin
                                n_t0_rr   = r_t0_rr && char_match(KW_RR, LEN_RR, r_t0_len, c);
                                n_t0_vbat = r_t0_vbat &&
                                            char_match(KW_VBAT, LEN_VBAT, r_t0_len, c);
                                n_t0_scan = r_t0_scan &&
                                            char_match(KW_SCAN, LEN_SCAN, r_t0_len, c);
                                if (r_t0_len != 3'd7) begin
                                    n_t0_len = r_t0_len + 3'd1;
                                end
                            end
                            3'd1: begin
                                n_t1_on  = r_t1_on && char_match(KW_ON, LEN_ON, r_t1_len, c_low);
                                n_t1_off = r_t1_off &&
                                           char_match(KW_OFF, LEN_OFF, r_t1_len, c_low);
                                if (r_t1_len != 3'd7) begin
                                    n_t1_len = r_t1_len + 3'd1;
                                end
                                n_num1 = num_step(r_num1, c);
                            end
                            3'd2: begin
                                n_num2 = num_step(r_num2, c);
                            end
                            default: begin
                                n_num2 = r_num2;
                            end
                        endcase
                    end
                end
            end else begin
                if (i_cmd.kind == CMD_END) begin
                    n_out_valid = 1'b1;
                    n_result    = line_res;
                end
                n_ended   = 1'b0;
                n_in_tok  = 1'b0;
                n_ntok    = 3'd0;
                n_t0_len  = 3'd0;
                n_t0_rr   = 1'b1;
                n_t0_vbat = 1'b1;
                n_t0_scan = 1'b1;
                n_t1_len  = 3'd0;
                n_t1_on   = 1'b1;
                n_t1_off  = 1'b1;
                n_num1    = NUM_INIT;
                n_num2    = NUM_INIT;
            end
        end

        o_out_valid = r_out_valid;
        o_result    = r_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended     <= 1'b0;
            r_in_tok    <= 1'b0;
            r_ntok      <= 3'd0;
            r_t0_len    <= 3'd0;
            r_t0_rr     <= 1'b1;
            r_t0_vbat   <= 1'b1;
            r_t0_scan   <= 1'b1;
            r_t1_len    <= 3'd0;
            r_t1_on     <= 1'b1;
            r_t1_off    <= 1'b1;
            r_num1      <= NUM_INIT;
            r_num2      <= NUM_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_ended     <= n_ended;
            r_in_tok    <= n_in_tok;
            r_ntok      <= n_ntok;
            r_t0_len    <= n_t0_len;
            r_t0_rr     <= n_t0_rr;
            r_t0_vbat   <= n_t0_vbat;
            r_t0_scan   <= n_t0_scan;
            r_t1_len    <= n_t1_len;
            r_t1_on     <= n_t1_on;
            r_t1_off    <= n_t1_off;
            r_num1      <= n_num1;
            r_num2      <= n_num2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

endmodule

// ----- test/line_command_parser_checker.sv -----
// checker for the line command parser: follows the byte and result requests and checks results
`timescale 1ns / 100ps

module line_command_parser_checker #(
    parameter int LINE_BYTES = lcp_pkg::LINE_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lcp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic                            i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [2:0]                      i_line_status,
    input  logic [15:0]                     i_first_value,
    input  logic [15:0]                     i_second_value,
    output int                              o_fail_count,
    output int                              o_pending
);
    import lcp_pkg::*;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;

    logic [7:0]  line_text [LINE_BYTES];
    int          fill_len = 0;
    int          mismatches = 0;
    t_lcp_cfg    enables = '1;
    t_lcp_result expected_lines [$];

    function automatic bit next_word(input int stop, inout int pos, output int ws,
                                     output int wl);
        ws = pos;
        wl = 0;
        while (pos < stop && line_text[pos] == CH_SPACE) pos++;
        if (pos >= stop) return 1'b0;
        ws = pos;
        while (pos < stop && line_text[pos] != CH_SPACE) pos++;
        wl = pos - ws;
        return 1'b1;
    endfunction

    function automatic bit word_is(input int ws, input int wl, input logic [31:0] kw,
                                   input logic [2:0] kw_len, input bit fold);
        logic [7:0] c;
        logic [7:0] k;
        if (wl != int'(kw_len)) return 1'b0;
        for (int i = 0; i < int'(kw_len); i++) begin
            c = line_text[ws + i];
            k = kw[31 - 8 * i -: 8];
            if (fold) begin
                if (c >= CH_UP_A && c <= CH_UP_Z) c = c + 8'd32;
                if (k >= CH_UP_A && k <= CH_UP_Z) k = k + 8'd32;
            end
            if (c != k) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [15:0] token_value(input int ws, input int wl);
        int          p;
        int          stop;
        bit          neg;
        logic [15:0] v;
        p = ws;
        stop = ws + wl;
        neg = 1'b0;
        v = '0;
        while (p < stop && (line_text[p] == CH_SPACE ||
               (line_text[p] >= CH_TAB && line_text[p] <= CH_CR))) p++;
        if (p < stop && (line_text[p] == CH_PLUS || line_text[p] == CH_MINUS)) begin
            neg = line_text[p] == CH_MINUS;
            p++;
        end
        while (p < stop && line_text[p] >= CH_ZERO && line_text[p] <= CH_NINE) begin
            v = v * 16'd10 + {8'h00, line_text[p] - CH_ZERO};
            p++;
        end
        if (neg) v = 16'd0 - v;
        return v;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lcp_result want;
        t_lcp_result line_out;
        int          stop;
        int          pos;
        int          s0, l0, s1, l1, s2, l2;
        if (!i_rst_n) begin
            fill_len = 0;
            enables = '1;
            expected_lines.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_lines.size() == 0) begin
                    $error("result with no line pending: line_status %0d", i_line_status);
                    mismatches++;
                end else begin
                    want = expected_lines.pop_front();
                    if (i_line_status !== want.line_status) begin
                        $error("line_status: expected %0d, got %0d",
                               want.line_status, i_line_status);
                        mismatches++;
                    end
                    if (i_first_value !== want.first_value) begin
                        $error("first_value: expected %0d, got %0d",
                               want.first_value, i_first_value);
                        mismatches++;
                    end
                    if (i_second_value !== want.second_value) begin
                        $error("second_value: expected %0d, got %0d",
                               want.second_value, i_second_value);
                        mismatches++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (i_rx_byte == CH_NL) begin
                    if (fill_len != 0) begin
                        stop = 0;
                        while (stop < fill_len && line_text[stop] != CH_NUL) stop++;
                        pos = 0;
                        line_out.line_status = ST_NO_ACTION;
                        line_out.first_value = '0;
                        line_out.second_value = '0;
                        if (!next_word(stop, pos, s0, l0)) begin
                            line_out.line_status = ST_REJECT;
                        end else if (enables.rr_enable &&
                                     word_is(s0, l0, KW_RR, LEN_RR, 1'b0)) begin
                            if (next_word(stop, pos, s1, l1) &&
                                next_word(stop, pos, s2, l2)) begin
                                line_out.line_status = ST_RR;
                                line_out.first_value = token_value(s1, l1);
                                line_out.second_value = token_value(s2, l2);
                            end else begin
                                line_out.line_status = ST_REJECT;
                            end
                        end else if (enables.vbat_enable &&
                                     word_is(s0, l0, KW_VBAT, LEN_VBAT, 1'b0)) begin
                            if (next_word(stop, pos, s1, l1)) begin
                                line_out.line_status = ST_VBAT;
                                line_out.first_value = token_value(s1, l1);
                            end else begin
                                line_out.line_status = ST_REJECT;
                            end
                        end else if (enables.scan_enable &&
                                     word_is(s0, l0, KW_SCAN, LEN_SCAN, 1'b0)) begin
                            if (next_word(stop, pos, s1, l1)) begin
                                if (word_is(s1, l1, KW_ON, LEN_ON, 1'b1))
                                    line_out.line_status = ST_SCAN_ON;
                                else if (word_is(s1, l1, KW_OFF, LEN_OFF, 1'b1))
                                    line_out.line_status = ST_SCAN_OFF;
                            end else begin
                                line_out.line_status = ST_REJECT;
                            end
                        end
                        expected_lines.push_back(line_out);
                        fill_len = 0;
                    end
                end else begin
                    line_text[fill_len] = i_rx_byte;
                    fill_len++;
                    // full store is thrown away without a result
                    if (fill_len >= LINE_BYTES) fill_len = 0;
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RR_ENABLE:   enables.rr_enable = i_cfg_data;
                    CFG_VBAT_ENABLE: enables.vbat_enable = i_cfg_data;
                    CFG_SCAN_ENABLE: enables.scan_enable = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending <= expected_lines.size();
    end

endmodule

// ----- test/line_command_parser_top_tb.sv -----
// testbench top for the line command parser: clock, reset, byte stimulus and verdict
`timescale 1ns / 100ps

module line_command_parser_top_tb;
    import lcp_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int SEGMENT_BYTES = 100;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} t_rx_pattern;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_RR_ENABLE;
    logic                   i_cfg_data = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [7:0]             i_rx_byte = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [2:0]             o_line_status;
    logic [15:0]            o_first_value;
    logic [15:0]            o_second_value;

    int          fail_count;
    int          pending;
    logic [7:0]  line_buf [$];
    int          burst_left = 0;
    bit          steady = 1'b0;
    int          bytes_sent = 0;
    int          holds_asked = 0;
    int          holds_done = 0;
    t_rx_pattern rx_pattern = RX_OPEN;
    int          rx_left = 0;

    line_command_parser_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_line_status  (o_line_status),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value)
    );

    line_command_parser_checker line_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_line_status  (o_line_status),
        .i_first_value  (o_first_value),
        .i_second_value (o_second_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side stall pattern
    always @(posedge i_clk) begin
        if (holds_done < holds_asked) begin
            rx_pattern = RX_HOLD;
            rx_left = HOLD_CYCLES;
            holds_done++;
        end else if (rx_left == 0) begin
            rx_pattern = t_rx_pattern'($urandom_range(0, 2));
            rx_left = $urandom_range(8, 80);
        end else begin
            rx_left--;
        end
        case (rx_pattern)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:   i_out_ready <= 1'b0;
        endcase
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    function automatic void put(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void put_cased(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if ($urandom_range(0, 1) == 1) c = c ^ 8'h20;
            line_buf.push_back(c);
        end
    endfunction

    function automatic void put_spaces(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) line_buf.push_back(CH_SPACE);
    endfunction

    function automatic void put_number();
        int n;
        if ($urandom_range(0, 7) == 0) line_buf.push_back(8'($urandom_range(CH_TAB, CH_CR)));
        case ($urandom_range(0, 3))
            0: line_buf.push_back(CH_PLUS);
            1: line_buf.push_back(CH_MINUS);
            default: ;
        endcase
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 5);
        repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0) put("x7");
    endfunction

    task automatic flush_line();
        foreach (line_buf[i]) send_byte(line_buf[i]);
        line_buf.delete();
    endtask

    task automatic send_line(input string s);
        put(s);
        line_buf.push_back(CH_NL);
        flush_line();
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_enables(input bit rr, input bit vbat, input bit scan);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_RR_ENABLE;
        i_cfg_data <= rr;
        @(posedge i_clk);
        i_cfg_index <= CFG_VBAT_ENABLE;
        i_cfg_data <= vbat;
        @(posedge i_clk);
        i_cfg_index <= CFG_SCAN_ENABLE;
        i_cfg_data <= scan;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int target;
        int pick;
        bit paused;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines with every enable set
        set_enables(1'b1, 1'b1, 1'b1);
        send_line("RR 90 100");
        send_line("RR -1 65535");
        send_line("RR +70000 0099 extra");
        send_line("VBAT 1234");
        send_line("VBAT abc");
        send_line("VBAT \t-12x");
        send_line("SCAN on");
        send_line("SCAN OFF");
        send_line("SCAN oN extra");
        send_line("SCAN offf");
        send_line("RR 5");
        send_line("VBAT");
        send_line("SCAN   ");
        send_line("    ");
        send_line("");
        send_line("HELLO 1");
        send_line("rr 1 2");
        send_line("  RR  3  4 ");
        put("RR");
        line_buf.push_back(CH_NUL);
        send_line(" 1 2");
        line_buf.push_back(CH_NUL);
        send_line("VBAT 5");
        put("VBAT 9");
        line_buf.push_back(8'hFF);
        send_line("");
        repeat (64) put("A");
        send_line("VBAT 7");
        repeat (63) put("B");
        send_line("");

        // every keyword disabled
        set_enables(1'b0, 1'b0, 1'b0);
        send_line("RR 1 2");
        send_line("VBAT 3");
        send_line("SCAN on");
        send_line("SCAN");

        paused = 1'b0;
        for (int seg = 0; seg < 5; seg++) begin
            case (seg)
                0, 4:    set_enables(1'b1, 1'b1, 1'b1);
                default: set_enables(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)));
            endcase
            steady = (seg == 1 || seg == 3);
            if (seg == 1) holds_asked++;
            target = bytes_sent + SEGMENT_BYTES;
            while (bytes_sent < target) begin
                if (seg == 2 && !paused && bytes_sent > target - SEGMENT_BYTES / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 5) == 0) put_spaces(1, 3);
                if (pick < 26) begin
                    put("RR");
                    put_spaces(1, 3);
                    put_number();
                    put_spaces(1, 3);
                    put_number();
                    if ($urandom_range(0, 4) == 0) begin
                        put_spaces(1, 2);
                        put_number();
                    end
                end else if (pick < 46) begin
                    put("VBAT");
                    put_spaces(1, 3);
                    put_number();
                end else if (pick < 64) begin
                    put("SCAN");
                    put_spaces(1, 3);
                    case ($urandom_range(0, 5))
                        0, 1:    put_cased("on");
                        2, 3:    put_cased("off");
                        4:       put_cased("of");
                        default: put_cased("onn");
                    endcase
                    if ($urandom_range(0, 4) == 0) begin
                        put_spaces(1, 2);
                        put_number();
                    end
                end else if (pick < 72) begin
                    // keyword with missing arguments
                    case ($urandom_range(0, 3))
                        0: put("RR");
                        1: begin
                            put("RR");
                            put_spaces(1, 2);
                            put_number();
                        end
                        2: put("VBAT");
                        default: put("SCAN");
                    endcase
                    put_spaces(0, 2);
                end else if (pick < 80) begin
                    case ($urandom_range(0, 3))
                        0: put_cased("rr");
                        1: put("VBA");
                        2: put_cased("scanx");
                        default: repeat ($urandom_range(1, 6))
                            line_buf.push_back(8'($urandom_range(65, 90)));
                    endcase
                    put_spaces(1, 2);
                    put_number();
                end else if (pick < 86) begin
                    repeat ($urandom_range(1, 20))
                        line_buf.push_back(8'($urandom_range(0, 255)));
                end else if (pick < 90) begin
                    // long lines around the store size
                    repeat ($urandom_range(60, 80))
                        line_buf.push_back(8'($urandom_range(32, 126)));
                end else if (pick < 94) begin
                    put_spaces(0, 4);
                end else begin
                    put("VBAT ");
                    if ($urandom_range(0, 1) == 1) line_buf.push_back(CH_NUL);
                    put_number();
                    line_buf.push_back(CH_NUL);
                    put(" 9");
                end
                line_buf.push_back(CH_NL);
                flush_line();
            end
        end

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- line_command_parser_top.f -----
sv/lcp_pkg.sv
sv/lcp_front.sv
sv/lcp_queue.sv
sv/lcp_back.sv
sv/line_command_parser_top.sv
test/line_command_parser_checker.sv
test/line_command_parser_top_tb.sv
